FILE: hw/rtl/running_mean_variance_stats_top_assert.svh
// Assertion macros for the running statistics block.
// Included by running_mean_variance_stats_top; needs clk_i and rst_ni in scope.
`ifndef RUNNING_MEAN_VARIANCE_STATS_TOP_ASSERT_SVH
`define RUNNING_MEAN_VARIANCE_STATS_TOP_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define RMVS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Signal holds its value while the condition is true.
`define RMVS_HOLD(lbl, cond, sig) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> $stable(sig)) else $error("value changed");

`endif

FILE: hw/rtl/rmvs_pkg.sv
// Shared types and constants for the running statistics block.
// No dependencies.
`default_nettype none
package rmvs_pkg;
  localparam int unsigned CountBitsDef = 32;
  localparam int unsigned DivW = 64;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVF   = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;
endpackage
`default_nettype wire

FILE: hw/rtl/rmvs_div.sv
// Bit-serial unsigned restoring divider, one quotient bit per cycle.
// Depends on rmvs_pkg.
`default_nettype none
module rmvs_div #(
  parameter int unsigned DenW = rmvs_pkg::CountBitsDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [rmvs_pkg::DivW-1:0] num_i,
  input  wire logic [DenW-1:0]           den_i,
  output logic                           busy_o,
  output logic [rmvs_pkg::DivW-1:0]      quo_o
);
  localparam int unsigned W = rmvs_pkg::DivW;
  logic [W-1:0] quo_q, quo_d;
  logic [DenW:0] rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [6:0] cnt_q, cnt_d;
  logic [DenW:0] trial;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    trial = {rem_q[DenW-1:0], quo_q[W-1]};
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      cnt_d = 7'(W);
    end else if (cnt_q != '0) begin
      quo_d = {quo_q[W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

FILE: hw/rtl/running_mean_variance_stats_top.sv
// Top level of the running mean and variance statistics block.
// Depends on rmvs_pkg, rmvs_div and running_mean_variance_stats_top_assert.svh.
//
//   channel | dir | tdata fields (low bit first)             | tuser
//   s_axis  | in  | sample[31:0]                             | action
//   m_axis  | out | status, count, sum, mean, min, max, var  | -
//
// An accepted sample passes, before the next input beat, through a check step,
// the mean step on the shared bit-serial divider, the shift-and-add multiply
// with setup and check, the variance division and an output step. A clear,
// a first sample, a count or sum reject and a deviation reject end earlier.
// Reset clears all statistics; input is refused while a beat is in work.
`default_nettype none
module running_mean_variance_stats_top #(
  parameter int unsigned COUNT_BITS = rmvs_pkg::CountBitsDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,   // sample[31:0]
  input  wire logic         s_axis_tuser,   // action
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status[1:0], sample_count[33:2], running_sum[81:34], mean_value[113:82],
  // min_value[145:114], max_value[177:146], variance[241:178], zero fill
  output logic [247:0]      m_axis_tdata
);
  typedef enum logic [2:0] {
    S_IDLE, S_MEAN, S_MUL, S_VAR, S_OUT
  } state_e;

  state_e state_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic signed [47:0] sum_q, mean_q;
  logic [63:0] m2_q;
  logic signed [31:0] min_q, max_q;
  logic signed [31:0] smp_q;
  logic neg_q, ovf_q, wait_q;
  logic signed [48:0] d_q;
  // Multiply: |d| (50 bits) times |e| (50 bits) shifted bit by bit.
  logic [99:0] prod_q;
  logic [49:0] mcand_q, mplier_q;
  logic [5:0] mcnt_q;
  logic [63:0] var_q;

  logic div_start, div_busy;
  logic [63:0] div_num, div_quo;
  logic [COUNT_BITS-1:0] div_den;

  rmvs_div #(.DenW(COUNT_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num),
    .den_i(div_den), .busy_o(div_busy), .quo_o(div_quo)
  );

  logic signed [48:0] s32, sum_n, e_v;
  logic [48:0] d_abs, e_abs, q_sgn;
  logic signed [48:0] mean_n;
  logic [64:0] m2_n;
  logic [50:0] mul_acc;
  assign s32   = 49'(signed'({smp_q, 16'd0}));
  assign sum_n = 49'(sum_q) + 49'(smp_q);
  assign d_abs = d_q[48] ? 49'(-d_q) : 49'(d_q);
  assign q_sgn = neg_q ? 49'(-div_quo[48:0]) : div_quo[48:0];
  assign mean_n = 49'(mean_q) + signed'(q_sgn);
  assign e_v   = s32 - 49'(mean_q);
  assign e_abs = e_v[48] ? 49'(-e_v) : 49'(e_v);
  assign m2_n  = {1'b0, m2_q} + {1'b0, prod_q[95:32]};
  // Upper half of the product plus the multiplicand when the next bit is set.
  assign mul_acc = {1'b0, prod_q[99:50]} + (mplier_q[0] ? {1'b0, mcand_q} : 51'd0);

  always_comb begin
    div_start = 1'b0;
    div_num = 64'(d_abs);
    div_den = cnt_q + COUNT_BITS'(1);
    if (state_q == S_IDLE && s_axis_tvalid && s_axis_tready) begin
      div_start = 1'b0;
    end else if (state_q == S_MUL && mcnt_q == '0 && !wait_q) begin
      div_start = 1'b1;
      div_num = m2_n[63:0];
    end else if (wait_q && state_q == S_MEAN) begin
      div_start = 1'b1;
      div_num = 64'(e_abs);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0; sum_q <= '0; mean_q <= '0; m2_q <= '0;
      min_q <= '0; max_q <= '0; wait_q <= 1'b0;
      ovf_q <= 1'b0; smp_q <= '0; d_q <= '0; neg_q <= 1'b0;
      mcand_q <= '0; mplier_q <= '0; prod_q <= '0; mcnt_q <= '0;
      var_q <= '0;
    end else begin
      wait_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (s_axis_tvalid) begin
          smp_q <= s_axis_tdata;
          if (s_axis_tuser) begin
            cnt_q <= '0; sum_q <= '0; mean_q <= '0; m2_q <= '0;
            min_q <= '0; max_q <= '0; ovf_q <= 1'b0;
            var_q <= '0;
            state_q <= S_OUT;
          end else begin
            state_q <= S_MEAN; wait_q <= 1'b1;
          end
        end
        S_MEAN: if (wait_q) begin
          // Checks and the deviation d are formed now; divider starts.
          ovf_q <= (cnt_q == '1) || (sum_n[48] != sum_n[47]);
          d_q <= s32 - 49'(mean_q);
          neg_q <= s32 < 49'(mean_q);
          if (cnt_q == '0) begin
            state_q <= S_OUT;
            if (!(sum_n[48] != sum_n[47])) begin
              cnt_q <= COUNT_BITS'(1); sum_q <= sum_n[47:0];
              mean_q <= s32[47:0]; m2_q <= '0; var_q <= '0;
              min_q <= smp_q; max_q <= smp_q;
            end else ovf_q <= 1'b1;
          end
        end else if (ovf_q) begin
          state_q <= S_OUT;
        end else if (!div_busy) begin
          mean_q <= mean_n[47:0];
          mcand_q <= 50'(d_abs);
          mplier_q <= '0;
          prod_q <= '0; mcnt_q <= 6'd50; state_q <= S_MUL;
          wait_q <= 1'b1;
        end
        S_MUL: if (wait_q) begin
          mplier_q <= 50'(e_abs);
          mcnt_q <= 6'd50;
        end else if (mcnt_q != '0) begin
          prod_q <= {mul_acc, prod_q[49:1]};
          mplier_q <= mplier_q >> 1;
          mcnt_q <= mcnt_q - 6'd1;
        end else begin
          if (prod_q[99:96] != '0 || m2_n[64]) begin
            // Reject: restore the mean from before this beat.
            ovf_q <= 1'b1;
            mean_q <= 48'(mean_q - signed'(q_sgn));
            state_q <= S_OUT;
          end else begin
            cnt_q <= cnt_q + COUNT_BITS'(1);
            sum_q <= sum_n[47:0];
            m2_q <= m2_n[63:0];
            if (smp_q < min_q) min_q <= smp_q;
            if (smp_q > max_q) max_q <= smp_q;
            state_q <= S_VAR; wait_q <= 1'b1;
          end
        end
        S_VAR: if (!wait_q && !div_busy) begin
          var_q <= div_quo;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  logic [1:0] status_v;
  assign status_v = ovf_q ? rmvs_pkg::ST_OVF :
                    (cnt_q == '0 ? rmvs_pkg::ST_EMPTY : rmvs_pkg::ST_OK);
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata = {6'd0, var_q, max_q, min_q, mean_q[47:16], sum_q,
                         32'(cnt_q), status_v};

  `include "running_mean_variance_stats_top_assert.svh"
  `RMVS_ASSERT(a_one_side, !(s_axis_tready && m_axis_tvalid))
  `RMVS_HOLD(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tdata)
  `RMVS_ASSERT(a_minmax, (cnt_q != '0) |-> (min_q <= max_q))
endmodule
`default_nettype wire
